[rtl/ght_pkg.sv]
// package for the generation handle table: word types, status codes, sizes
// no dependencies
package ght_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int READ_CAP_DEFAULT = 4096;
    localparam logic [23:0] GEN_MAX = 24'hFFFFFF;
    localparam logic [15:0] TIMEOUT_MAX = 16'd60000;

    localparam logic [1:0] OP_OPEN = 2'd0;
    localparam logic [1:0] OP_ADVANCE = 2'd1;
    localparam logic [1:0] OP_SEEK = 2'd2;
    localparam logic [1:0] OP_CLOSE = 2'd3;

    localparam logic [1:0] WH_START = 2'd0;
    localparam logic [1:0] WH_CUR = 2'd1;
    localparam logic [1:0] WH_END = 2'd2;
    localparam logic [1:0] WH_BAD = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_INVAL = 3'd1;
    localparam logic [2:0] ST_BADH = 3'd2;
    localparam logic [2:0] ST_OVF = 3'd3;
    localparam logic [2:0] ST_FULL = 3'd4;
    localparam logic [2:0] ST_NOTFILE = 3'd5;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [31:0]        handle;
        logic [15:0]        open_timeout;
        logic               is_regular_file;
        logic [15:0]        read_capacity;
        logic [15:0]        read_amount;
        logic signed [63:0] seek_offset;
        logic [1:0]         seek_whence;
        logic [63:0]        file_size;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] handle_out;
        logic [31:0] position;
    } out_word_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
    } dp_cmd_t;

endpackage

[rtl/ght_ctrl.sv]
// controller for the generation handle table: load, execute, hold result
// depends on ght_pkg
module ght_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    output ght_pkg::dp_cmd_t cmd
);
    import ght_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_OUT = 2'd2;

    logic [1:0] state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_valid) state_next = S_EXEC;
            S_EXEC: state_next = S_OUT;
            S_OUT:  if (!out_stall) state_next = in_valid ? S_EXEC : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_IDLE;
        else        state_reg <= state_next;
    end

    // handshake and commands
    assign in_stall  = !((state_reg == S_IDLE) || (state_reg == S_OUT && !out_stall));
    assign out_valid = (state_reg == S_OUT);
    assign cmd.load  = in_valid && !in_stall;
    assign cmd.exec  = (state_reg == S_EXEC);
endmodule

[rtl/ght_dp.sv]
// datapath for the generation handle table: slot flags, generations, positions
// depends on ght_pkg
module ght_dp #(
    parameter int SLOTS = ght_pkg::SLOTS_DEFAULT,
    parameter int READ_CAP = ght_pkg::READ_CAP_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ght_pkg::dp_cmd_t  cmd,
    input  ght_pkg::in_word_t in_word,
    output ght_pkg::out_word_t out_word
);
    import ght_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [SLOTS-1:0] busy_reg, retired_reg;
    logic [23:0]      gen_reg [SLOTS];
    logic [31:0]      pos_reg [SLOTS];
    in_word_t         req_reg;
    out_word_t        res_reg;

    // capture request word
    always_ff @(posedge clk)
    begin
        if (cmd.load) req_reg <= in_word;
    end

    // handle check
    logic [7:0]    enc;
    logic [23:0]   hgen;
    logic [IW-1:0] hs;
    logic          hok;
    always_comb
    begin
        enc  = req_reg.handle[7:0];
        hgen = req_reg.handle[31:8];
        hs   = IW'(enc - 8'd1);
        hok  = (enc != 8'd0) && ({24'd0, enc} <= 32'(SLOTS)) && (hgen != 24'd0)
            && busy_reg[hs] && !retired_reg[hs] && (gen_reg[hs] == hgen);
    end

    // lowest free slot
    logic          free_found;
    logic [IW-1:0] free_idx;
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!busy_reg[i] && !retired_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    // operation result
    logic [2:0]  st;
    logic [31:0] hout, npos;
    logic        wr_open, wr_pos, wr_close;
    logic [23:0] fgen;
    logic [32:0] adv_sum, cand_add;
    logic [63:0] base, mag;
    always_comb
    begin
        st = ST_OK; hout = '0; npos = '0;
        wr_open = 1'b0; wr_pos = 1'b0; wr_close = 1'b0;
        fgen = (gen_reg[free_idx] == 24'd0) ? 24'd1 : gen_reg[free_idx];
        adv_sum = {1'b0, pos_reg[hs]} + {17'd0, req_reg.read_amount};
        base = '0;
        if (req_reg.seek_whence == WH_CUR) base = {32'd0, pos_reg[hs]};
        if (req_reg.seek_whence == WH_END) base = req_reg.file_size;
        mag = 64'd0 - req_reg.seek_offset;
        cand_add = {1'b0, base[31:0]} + {1'b0, req_reg.seek_offset[31:0]};
        case (req_reg.opcode)
            OP_OPEN:
            begin
                if (req_reg.open_timeout == 16'd0 || req_reg.open_timeout > TIMEOUT_MAX)
                    st = ST_INVAL;
                else if (!req_reg.is_regular_file) st = ST_NOTFILE;
                else if (!free_found) st = ST_FULL;
                else
                begin
                    wr_open = 1'b1;
                    hout = {fgen, 8'(32'(free_idx) + 1)};
                end
            end
            OP_ADVANCE:
            begin
                if (req_reg.read_capacity == 16'd0
                    || 32'(req_reg.read_capacity) > 32'(READ_CAP)) st = ST_INVAL;
                else if (!hok) st = ST_BADH;
                else if (adv_sum[32]) st = ST_OVF;
                else
                begin
                    wr_pos = 1'b1;
                    npos = adv_sum[31:0];
                end
            end
            OP_SEEK:
            begin
                if (req_reg.seek_whence == WH_BAD) st = ST_INVAL;
                else if (!hok) st = ST_BADH;
                else if (req_reg.seek_whence == WH_END && (!req_reg.is_regular_file
                         || req_reg.file_size[63:32] != 32'd0)) st = ST_OVF;
                else if (!req_reg.seek_offset[63])
                begin
                    if (req_reg.seek_offset[63:32] != 32'd0 || cand_add[32]) st = ST_OVF;
                    else
                    begin
                        wr_pos = 1'b1;
                        npos = cand_add[31:0];
                    end
                end
                else if (mag > base) st = ST_INVAL;
                else
                begin
                    wr_pos = 1'b1;
                    npos = base[31:0] - mag[31:0];
                end
            end
            default:
            begin
                if (!hok) st = ST_BADH;
                else wr_close = 1'b1;
            end
        endcase
    end

    // slot registers: busy and retired flags, generations, positions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= '0;
            retired_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                gen_reg[i] <= '0;
                pos_reg[i] <= '0;
            end
        end
        else if (cmd.exec)
        begin
            if (wr_open)
            begin
                busy_reg[free_idx] <= 1'b1;
                gen_reg[free_idx]  <= fgen;
                pos_reg[free_idx]  <= '0;
            end
            if (wr_pos) pos_reg[hs] <= npos;
            if (wr_close)
            begin
                busy_reg[hs] <= 1'b0;
                pos_reg[hs]  <= '0;
                if (gen_reg[hs] == GEN_MAX) retired_reg[hs] <= 1'b1;
                else gen_reg[hs] <= gen_reg[hs] + 24'd1;
            end
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (cmd.exec) res_reg <= '{status: st, handle_out: hout, position: npos};
    end

    assign out_word = res_reg;
endmodule

[rtl/generation_handle_table.sv]
// generation handle table: one request word in, one result word out
// the request word is registered at accept, then an execute step updates the slot registers
// and registers the result word; a new word is not accepted until the last result is taken
// reset clears all busy, retired, generation and position registers at once
// depends on ght_pkg, ght_ctrl, ght_dp
module generation_handle_table #(
    parameter int SLOTS = ght_pkg::SLOTS_DEFAULT,
    parameter int READ_CAP = ght_pkg::READ_CAP_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ght_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output ght_pkg::out_word_t out_data
);
    import ght_pkg::*;

    dp_cmd_t cmd;

    ght_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd)
    );

    ght_dp #(.SLOTS(SLOTS), .READ_CAP(READ_CAP)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_word(in_data), .out_word(out_data)
    );
endmodule

[test/tb.sv]
// testbench for generation_handle_table: directed table then random words,
// checked against a behavioral slot-table predictor; depends on ght_pkg
module tb;
    import ght_pkg::*;

    localparam int SLOTS = SLOTS_DEFAULT;
    localparam int READ_CAP = READ_CAP_DEFAULT;
    localparam int WATCHDOG_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_word_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b1;
    out_word_t out_data;

    // predictor state
    logic        busy_q [SLOTS];
    logic        retired_q [SLOTS];
    logic [23:0] gen_q [SLOTS];
    logic [31:0] pos_q [SLOTS];

    out_word_t result_q [$];
    // directed rows carry a typed-in status checked against the predictor; -1 means none
    int  errors = 0;
    int  words_sent = 0;
    int  words_checked = 0;
    int  idle_cycles = 0;
    int  stall_left = 0;
    bit  calm = 1'b0;
    logic [31:0] live_handles [$];

    generation_handle_table u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    always #2 clk = ~clk;

    // returns slot index or -1 for a bad handle
    function automatic int handle_slot(logic [31:0] h);
        int s;
        if (h[7:0] == 0 || h[7:0] > SLOTS || h[31:8] == 0)
            return -1;
        s = h[7:0] - 1;
        if (!busy_q[s] || retired_q[s] || gen_q[s] != h[31:8])
            return -1;
        return s;
    endfunction

    // compute the result word and update the slot table
    function automatic out_word_t table_step(in_word_t w);
        out_word_t r;
        int s;
        logic [63:0] base, cand, mag;
        logic [32:0] sum;
        r = '0;
        r.status = ST_OK;
        case (w.opcode)
            OP_OPEN:
            begin
                if (w.open_timeout == 0 || w.open_timeout > TIMEOUT_MAX)
                    r.status = ST_INVAL;
                else if (!w.is_regular_file)
                    r.status = ST_NOTFILE;
                else
                begin
                    r.status = ST_FULL;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!busy_q[i] && !retired_q[i] && r.status == ST_FULL)
                        begin
                            if (gen_q[i] == 0)
                                gen_q[i] = 24'd1;
                            pos_q[i] = '0;
                            busy_q[i] = 1'b1;
                            r.handle_out = {gen_q[i], 8'(i + 1)};
                            r.status = ST_OK;
                        end
                    end
                end
            end
            OP_ADVANCE:
            begin
                s = handle_slot(w.handle);
                if (w.read_capacity == 0 || w.read_capacity > READ_CAP)
                    r.status = ST_INVAL;
                else if (s < 0)
                    r.status = ST_BADH;
                else
                begin
                    sum = {1'b0, pos_q[s]} + {17'd0, w.read_amount};
                    if (sum[32])
                        r.status = ST_OVF;
                    else
                    begin
                        pos_q[s] = sum[31:0];
                        r.position = sum[31:0];
                    end
                end
            end
            OP_SEEK:
            begin
                s = handle_slot(w.handle);
                if (w.seek_whence > WH_END)
                    r.status = ST_INVAL;
                else if (s < 0)
                    r.status = ST_BADH;
                else
                begin
                    base = '0;
                    if (w.seek_whence == WH_CUR)
                        base = 64'(pos_q[s]);
                    if (w.seek_whence == WH_END)
                    begin
                        if (!w.is_regular_file || w.file_size > 64'hFFFFFFFF)
                            r.status = ST_OVF;
                        else
                            base = w.file_size;
                    end
                    if (r.status == ST_OK)
                    begin
                        if (!w.seek_offset[63])
                        begin
                            if (w.seek_offset > 64'hFFFFFFFF - base)
                                r.status = ST_OVF;
                            else
                                cand = base + w.seek_offset;
                        end
                        else
                        begin
                            mag = 64'd0 - w.seek_offset;
                            if (mag > base)
                                r.status = ST_INVAL;
                            else
                                cand = base - mag;
                        end
                    end
                    if (r.status == ST_OK)
                    begin
                        pos_q[s] = cand[31:0];
                        r.position = cand[31:0];
                    end
                end
            end
            default:
            begin
                s = handle_slot(w.handle);
                if (s < 0)
                    r.status = ST_BADH;
                else
                begin
                    pos_q[s] = '0;
                    busy_q[s] = 1'b0;
                    if (gen_q[s] == GEN_MAX)
                        retired_q[s] = 1'b1;
                    else
                        gen_q[s] = gen_q[s] + 24'd1;
                end
            end
        endcase
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want,
            words_checked);
        errors++;
    endtask

    // send one word, wait for acceptance, with optional gap first
    task automatic send_word(in_word_t w, int typed_status);
        out_word_t r;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = table_step(w);
        if (typed_status >= 0 && r.status != typed_status)
            report("typed status vs predictor", 64'(r.status), 64'(typed_status));
        if (r.status == ST_OK && w.opcode == OP_OPEN)
            live_handles.push_back(r.handle_out);
        result_q.push_back(r);
        words_sent++;
    endtask

    // base word with legal defaults
    function automatic in_word_t mk(logic [1:0] op, logic [31:0] h);
        in_word_t w;
        w = '0;
        w.opcode = op;
        w.handle = h;
        w.open_timeout = 16'd100;
        w.is_regular_file = 1'b1;
        w.read_capacity = 16'd512;
        return w;
    endfunction

    function automatic logic [31:0] pick_handle();
        logic [31:0] h;
        case ($urandom_range(0, 9))
            0: h = $urandom;
            1: h = {24'($urandom_range(0, 3)), 8'($urandom_range(0, 20))};
            2: h = {$urandom_range(0, 3) == 0 ? 24'hFFFFFF : 24'($urandom), 8'hFF};
            default:
            begin
                h = live_handles.size() ? live_handles[$urandom_range(0,
                    live_handles.size() - 1)] : 32'h101;
                if ($urandom_range(0, 9) == 0)
                    h[31:8] = h[31:8] + 24'd1;
            end
        endcase
        return h;
    endfunction

    function automatic in_word_t random_word();
        in_word_t w;
        int k;
        w = mk(2'($urandom_range(0, 3)), pick_handle());
        k = $urandom_range(0, 19);
        w.open_timeout = k == 0 ? 16'($urandom) : k == 1 ? 16'd0 :
            k == 2 ? 16'd60001 : 16'($urandom_range(1, 60000));
        w.is_regular_file = $urandom_range(0, 9) != 0;
        k = $urandom_range(0, 19);
        w.read_capacity = k == 0 ? 16'($urandom) : k == 1 ? 16'd0 :
            16'($urandom_range(1, READ_CAP));
        w.read_amount = $urandom_range(0, 3) == 0 ? 16'($urandom) :
            16'($urandom_range(0, 64));
        k = $urandom_range(0, 5);
        w.seek_offset = k == 0 ? {$urandom, $urandom} :
            k == 1 ? -64'($urandom_range(0, 5000)) :
            k == 2 ? 64'($urandom) : 64'($urandom_range(0, 5000));
        w.seek_whence = $urandom_range(0, 9) == 0 ? WH_BAD : 2'($urandom_range(0, 2));
        w.file_size = $urandom_range(0, 4) == 0 ? {$urandom, $urandom} :
            64'($urandom);
        return w;
    endfunction

    // output side: random stall bursts, check each accepted word
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                    report("unexpected result word", 64'(out_data.handle_out), 64'd0);
                else
                begin
                    want = result_q.pop_front();
                    if (out_data.status !== want.status)
                        report("status", 64'(out_data.status), 64'(want.status));
                    if (out_data.handle_out !== want.handle_out)
                        report("handle_out", 64'(out_data.handle_out),
                            64'(want.handle_out));
                    if (out_data.position !== want.position)
                        report("position", 64'(out_data.position), 64'(want.position));
                end
                words_checked++;
            end
            if (!calm && stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(0, 2);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        in_word_t w;
        logic [31:0] h0;
        for (int i = 0; i < SLOTS; i++)
        begin
            busy_q[i] = 1'b0;
            retired_q[i] = 1'b0;
            gen_q[i] = '0;
            pos_q[i] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: extremes, every op, each error case
        send_word(mk(OP_ADVANCE, 32'h101), ST_BADH);
        w = mk(OP_OPEN, 32'd0); w.open_timeout = 16'd0; send_word(w, ST_INVAL);
        w = mk(OP_OPEN, 32'd0); w.open_timeout = 16'd60001; send_word(w, ST_INVAL);
        w = mk(OP_OPEN, 32'd0); w.open_timeout = 16'hFFFF; send_word(w, ST_INVAL);
        w = mk(OP_OPEN, 32'd0); w.is_regular_file = 1'b0; send_word(w, ST_NOTFILE);
        w = mk(OP_OPEN, 32'd0); w.open_timeout = 16'd60000; send_word(w, ST_OK);
        h0 = 32'h101;
        w = mk(OP_ADVANCE, h0); w.read_capacity = 16'd0; send_word(w, ST_INVAL);
        w = mk(OP_ADVANCE, h0); w.read_capacity = 16'd4097; send_word(w, ST_INVAL);
        w = mk(OP_ADVANCE, h0); w.read_capacity = 16'd4096; w.read_amount = 16'hFFFF;
        send_word(w, ST_OK);
        w = mk(OP_ADVANCE, h0); send_word(w, ST_OK);
        w = mk(OP_SEEK, h0); w.seek_whence = WH_BAD; send_word(w, ST_INVAL);
        w = mk(OP_SEEK, h0); w.seek_offset = 64'hFFFFFFFF; send_word(w, ST_OK);
        w = mk(OP_ADVANCE, h0); w.read_amount = 16'd1; send_word(w, ST_OVF);
        w = mk(OP_SEEK, h0); w.seek_whence = WH_CUR; w.seek_offset = 64'd1;
        send_word(w, ST_OVF);
        w = mk(OP_SEEK, h0); w.seek_whence = WH_END; w.file_size = 64'h1_0000_0000;
        send_word(w, ST_OVF);
        w = mk(OP_SEEK, h0); w.seek_whence = WH_END; w.is_regular_file = 1'b0;
        send_word(w, ST_OVF);
        w = mk(OP_SEEK, h0); w.seek_whence = WH_END; w.file_size = 64'd10;
        w.seek_offset = -64'sd11; send_word(w, ST_INVAL);
        w = mk(OP_SEEK, h0); w.seek_whence = WH_END; w.file_size = 64'd10;
        w.seek_offset = 64'h8000_0000_0000_0000; send_word(w, ST_INVAL);
        w = mk(OP_SEEK, h0); w.seek_offset = 64'h7FFF_FFFF_FFFF_FFFF; send_word(w, ST_OVF);
        send_word(mk(OP_SEEK, 32'h100), ST_BADH);
        send_word(mk(OP_CLOSE, 32'hFFFF_FFFF), ST_BADH);
        send_word(mk(OP_CLOSE, h0), ST_OK);
        send_word(mk(OP_CLOSE, h0), ST_BADH);
        // fill the table past full
        for (int i = 0; i <= SLOTS; i++)
            send_word(mk(OP_OPEN, 32'd0), -1);

        // let every expected result drain before going random
        in_valid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);

        for (int n = 0; n < 800; n++)
        begin
            if (n == 650)
                calm = 1'b1;
            w = random_word();
            // close-then-reopen sequences keep slots cycling
            if (n % 40 == 0 && live_handles.size() > 0)
                w = mk(OP_CLOSE, live_handles.pop_front());
            send_word(w, -1);
        end
        in_valid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("ran %0d request words, %0d results checked, across all opcodes",
            words_sent, words_checked);
        if (errors == 0 && result_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

[sim.f]
rtl/ght_pkg.sv
rtl/ght_ctrl.sv
rtl/ght_dp.sv
rtl/generation_handle_table.sv
test/tb.sv
